// ===== src/lrupr_pkg.sv =====
package lrupr_pkg;

    // Default sizes of the frame store.
    localparam int DEF_NUM_FRAMES = 8;
    localparam int DEF_PAGE_BITS  = 8;

    // Fixed widths of the ports.
    localparam int PAGE_W  = 8;
    localparam int FAULT_W = 16;
    localparam int CFG_W   = 4;

    // Capacity after reset, before clamping to the frame count.
    localparam int CAP_RESET = 8;

    // One result of the frame store.
    typedef struct packed {
        logic               hit;
        logic               evicted_valid;
        logic [PAGE_W-1:0]  evicted_page;
        logic [FAULT_W-1:0] fault_total;
    } lrupr_result_t;

endpackage

// ===== src/lrupr_pipe_reg.sv =====
module lrupr_pipe_reg #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [WIDTH-1:0] s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [WIDTH-1:0] m_data
);

    logic             valid_reg;
    logic [WIDTH-1:0] data_reg;

    // The stage takes a new request when empty or when its content leaves.
    assign s_ready = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            data_reg <= s_data;
        end
    end

endmodule

// ===== src/lrupr_frame_store.sv =====
module lrupr_frame_store #(
    parameter int NUM_FRAMES = lrupr_pkg::DEF_NUM_FRAMES,
    parameter int PAGE_BITS  = lrupr_pkg::DEF_PAGE_BITS,
    parameter int CNT_W      = $clog2(NUM_FRAMES + 1)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        take,
    input  logic [lrupr_pkg::PAGE_W-1:0] page_in,
    input  logic [CNT_W-1:0]            capacity,
    output lrupr_pkg::lrupr_result_t    result
);

    localparam int RANK_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int IDX_W  = RANK_W;
    localparam int PAGE_W = lrupr_pkg::PAGE_W;
    localparam int FAULT_W = lrupr_pkg::FAULT_W;

    logic [PAGE_BITS-1:0]  page_reg   [NUM_FRAMES];
    logic [PAGE_BITS-1:0]  page_next  [NUM_FRAMES];
    logic [RANK_W-1:0]     rank_reg   [NUM_FRAMES];
    logic [RANK_W-1:0]     rank_next  [NUM_FRAMES];
    logic [NUM_FRAMES-1:0] valid_reg;
    logic [NUM_FRAMES-1:0] valid_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [FAULT_W-1:0]    fault_reg;
    logic [FAULT_W-1:0]    fault_next;

    logic [PAGE_BITS-1:0]  page;
    logic [NUM_FRAMES-1:0] hit_vec;
    logic [NUM_FRAMES-1:0] free_vec;
    logic [NUM_FRAMES-1:0] lru_vec;
    logic [IDX_W-1:0]      hit_idx;
    logic [IDX_W-1:0]      free_idx;
    logic [IDX_W-1:0]      lru_idx;
    logic [IDX_W-1:0]      victim_idx;
    logic [RANK_W-1:0]     hit_rank;
    logic [CNT_W-1:0]      oldest_rank;
    logic                  hit;
    logic                  full;
    logic [PAGE_BITS-1:0]  victim_page;
    logic [PAGE_W-1:0]     victim_page_out;

    // Fit the port's page number to the stored page width.
    generate
        if (PAGE_BITS > PAGE_W) begin : g_page_wide
            assign page            = {{(PAGE_BITS-PAGE_W){1'b0}}, page_in};
            assign victim_page_out = victim_page[PAGE_W-1:0];
        end else if (PAGE_BITS == PAGE_W) begin : g_page_same
            assign page            = page_in;
            assign victim_page_out = victim_page;
        end else begin : g_page_narrow
            assign page            = page_in[PAGE_BITS-1:0];
            assign victim_page_out = {{(PAGE_W-PAGE_BITS){1'b0}}, victim_page};
        end
    endgenerate

    // Valid frames hold distinct ranks 0..count-1, so the oldest has count-1.
    assign oldest_rank = count_reg - CNT_W'(1);

    // Tag compare, free frame and oldest frame, each with a priority pick.
    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        lru_idx  = '0;
        for (int i = 0; i < NUM_FRAMES; i++) begin
            hit_vec[i]  = valid_reg[i] && (page_reg[i] == page);
            free_vec[i] = !valid_reg[i];
            lru_vec[i]  = valid_reg[i] && (CNT_W'(rank_reg[i]) == oldest_rank);
        end
        for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                hit_idx = IDX_W'(i);
            end
            if (free_vec[i]) begin
                free_idx = IDX_W'(i);
            end
            if (lru_vec[i]) begin
                lru_idx = IDX_W'(i);
            end
        end
    end

    assign hit         = |hit_vec;
    assign full        = (count_reg >= capacity);
    assign hit_rank    = rank_reg[hit_idx];
    assign victim_idx  = full ? lru_idx : free_idx;
    assign victim_page = page_reg[lru_idx];

    // Next state of the frames for this request.
    always_comb begin
        for (int i = 0; i < NUM_FRAMES; i++) begin
            page_next[i]  = page_reg[i];
            rank_next[i]  = rank_reg[i];
            valid_next[i] = valid_reg[i];
            if (hit) begin
                if (IDX_W'(i) == hit_idx) begin
                    rank_next[i] = '0;
                end else if (valid_reg[i] && (rank_reg[i] < hit_rank)) begin
                    rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
            end else begin
                if (IDX_W'(i) == victim_idx) begin
                    page_next[i]  = page;
                    rank_next[i]  = '0;
                    valid_next[i] = 1'b1;
                end else if (valid_reg[i]) begin
                    rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
            end
        end
        count_next = count_reg;
        fault_next = fault_reg;
        if (!hit) begin
            if (!full) begin
                count_next = count_reg + CNT_W'(1);
            end
            if (fault_reg != '1) begin
                fault_next = fault_reg + FAULT_W'(1);
            end
        end
    end

    // Result of this request.
    always_comb begin
        result.hit           = hit;
        result.evicted_valid = !hit && full;
        result.evicted_page  = (!hit && full) ? victim_page_out : '0;
        result.fault_total   = fault_next;
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            count_reg <= '0;
            fault_reg <= '0;
        end else if (take) begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            fault_reg <= fault_next;
        end
    end

    // Pages and ranks of invalid frames are never read.
    always_ff @(posedge aclk) begin
        if (take) begin
            for (int i = 0; i < NUM_FRAMES; i++) begin
                page_reg[i] <= page_next[i];
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    // The fill count tracks the number of valid frames.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_reg) == int'(count_reg))
        else $error("fill count does not match valid frames");

    // A page is resident in at most one frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(hit_vec))
        else $error("page resident in more than one frame");

    // A nonempty store has exactly one oldest frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0) |-> $onehot(lru_vec))
        else $error("ranks of valid frames are not distinct");

    // A miss while not full always finds a free frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (take && !hit && !full) |-> (free_vec != '0))
        else $error("no free frame below capacity");

    // The fault counter never goes down outside reset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (fault_reg >= $past(fault_reg)))
        else $error("fault counter decreased");

endmodule

// ===== src/lru_page_replacement_core.sv =====
// Least-recently-used page frame store, fully associative.
//
// Input channel (s_valid / s_ready / s_page_number): one page reference per
// request. Result channel (m_valid / m_ready / m_*): one result per request,
// in order: hit flag, evicted page if any, and the saturating fault count.
// Configuration channel (cfg_valid / cfg_ready / cfg_data): sets the number
// of frames in use; 0 acts as 1 and values above NUM_FRAMES act as
// NUM_FRAMES. cfg_ready is always high; write only while the block is idle.
//
// A request enters an input register, is matched against all frames there,
// and updates the ranks as it moves on into the output register, where its
// result lands and raises m_valid. A new request is taken every cycle while
// the receiver takes results, since the compare and rank update over all
// frames are combinational.
//
// Reset empties all frames, clears the fault count and sets the capacity
// to 8 frames (or NUM_FRAMES if smaller). When the receiver stalls, the
// output and input registers fill and s_ready drops; nothing is lost.
module lru_page_replacement_core #(
    parameter int NUM_FRAMES = lrupr_pkg::DEF_NUM_FRAMES,
    parameter int PAGE_BITS  = lrupr_pkg::DEF_PAGE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [lrupr_pkg::PAGE_W-1:0]  s_page_number,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_hit,
    output logic                          m_evicted_valid,
    output logic [lrupr_pkg::PAGE_W-1:0]  m_evicted_page,
    output logic [lrupr_pkg::FAULT_W-1:0] m_fault_total,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lrupr_pkg::CFG_W-1:0]   cfg_data
);

    localparam int CNT_W    = $clog2(NUM_FRAMES + 1);
    localparam int CAP_INIT = (lrupr_pkg::CAP_RESET > NUM_FRAMES) ?
                              NUM_FRAMES : lrupr_pkg::CAP_RESET;
    localparam int RES_W    = $bits(lrupr_pkg::lrupr_result_t);

    logic [CNT_W-1:0]                  cap_reg;
    logic [CNT_W-1:0]                  cap_next;
    logic                              req_valid;
    logic [lrupr_pkg::PAGE_W-1:0]      req_page;
    logic                              res_ready;
    logic                              take;
    lrupr_pkg::lrupr_result_t          res;
    lrupr_pkg::lrupr_result_t          res_out;
    logic [RES_W-1:0]                  res_out_bits;

    // Capacity register, clamped to 1..NUM_FRAMES on write.
    assign cfg_ready = 1'b1;

    always_comb begin
        if (cfg_data == '0) begin
            cap_next = CNT_W'(1);
        end else if (32'(cfg_data) > NUM_FRAMES) begin
            cap_next = CNT_W'(NUM_FRAMES);
        end else begin
            cap_next = CNT_W'(cfg_data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CNT_W'(CAP_INIT);
        end else if (cfg_valid && cfg_ready) begin
            cap_reg <= cap_next;
        end
    end

    // Input register.
    lrupr_pipe_reg #(
        .WIDTH (lrupr_pkg::PAGE_W)
    ) u_in_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_page_number),
        .m_valid (req_valid),
        .m_ready (res_ready),
        .m_data  (req_page)
    );

    // The frame state advances when a request moves into the output register.
    assign take = req_valid && res_ready;

    lrupr_frame_store #(
        .NUM_FRAMES (NUM_FRAMES),
        .PAGE_BITS  (PAGE_BITS),
        .CNT_W      (CNT_W)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .take     (take),
        .page_in  (req_page),
        .capacity (cap_reg),
        .result   (res)
    );

    // Output register.
    lrupr_pipe_reg #(
        .WIDTH (RES_W)
    ) u_out_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (req_valid),
        .s_ready (res_ready),
        .s_data  (res),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (res_out_bits)
    );

    assign res_out         = lrupr_pkg::lrupr_result_t'(res_out_bits);
    assign m_hit           = res_out.hit;
    assign m_evicted_valid = res_out.evicted_valid;
    assign m_evicted_page  = res_out.evicted_page;
    assign m_fault_total   = res_out.fault_total;

endmodule
